### rtl/mlvr_pkg.sv
// Shared types, constants and tables for the mouse-look vector rotator.
// Used by mlvr_cordic, mlvr_rotate and mouse_look_vector_rotator_core.
package mlvr_pkg;

   localparam int SCREEN_WIDTH = 1024;
   localparam logic signed [13:0] CENTER_X = 14'(SCREEN_WIDTH / 2);
   localparam logic signed [14:0] SCREEN_LIMIT = 15'(SCREEN_WIDTH);

   localparam int CORDIC_STEPS = 14;
   localparam logic [3:0] LAST_STEP = 4'(CORDIC_STEPS - 1);
   localparam logic signed [31:0] CORDIC_START = 32'sd652032874;

   localparam logic [15:0] RST_SENSITIVITY = 16'd5340;
   localparam logic [9:0] RST_EDGE_MARGIN = 10'd100;
   localparam logic [15:0] RST_START_DIR_X = 16'd16384;
   localparam logic [15:0] RST_START_DIR_Y = 16'd0;
   localparam logic [15:0] RST_START_PLANE_X = 16'd0;
   localparam logic [15:0] RST_START_PLANE_Y = 16'd10813;

   typedef enum logic [2:0] {
      CSR_SENSITIVITY,
      CSR_EDGE_MARGIN,
      CSR_START_DIR_X,
      CSR_START_DIR_Y,
      CSR_START_PLANE_X,
      CSR_START_PLANE_Y
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] plane_y;
      logic signed [15:0] plane_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_x;
   } vec_type;

   typedef struct packed {
      logic signed [31:0] sin_v;
      logic signed [31:0] cos_v;
   } trig_type;

   function automatic logic [15:0] atan_unit(input logic [3:0] step);
      logic [15:0] v;
      case (step)
         4'd0: v = 16'd8192;
         4'd1: v = 16'd4836;
         4'd2: v = 16'd2555;
         4'd3: v = 16'd1297;
         4'd4: v = 16'd651;
         4'd5: v = 16'd326;
         4'd6: v = 16'd163;
         4'd7: v = 16'd81;
         4'd8: v = 16'd41;
         4'd9: v = 16'd20;
         4'd10: v = 16'd10;
         4'd11: v = 16'd5;
         4'd12: v = 16'd3;
         4'd13: v = 16'd1;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

endpackage

### rtl/mlvr_cordic.sv
// Iterative CORDIC sine/cosine: one shift-add rotation step per cycle, then quarter fold.
// Depends on mlvr_pkg.
module mlvr_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [15:0]         angle,
   output logic                done,
   output mlvr_pkg::trig_type  trig
);
   import mlvr_pkg::*;

   logic               busy_ff, fin_ff, done_ff;
   logic [3:0]         step_ff;
   logic signed [31:0] x_ff, y_ff;
   logic signed [15:0] z_ff;
   logic [1:0]         quad_ff;
   trig_type           trig_ff;

   logic signed [31:0] dx_in, dy_in;
   logic signed [15:0] at_in;
   logic               pos_in;
   trig_type           trig_in;

   always_comb begin
      dx_in  = y_ff >>> step_ff;
      dy_in  = x_ff >>> step_ff;
      at_in  = $signed(atan_unit(step_ff));
      pos_in = !z_ff[15];
      case (quad_ff)
         2'd0: begin
            trig_in.cos_v = x_ff;
            trig_in.sin_v = y_ff;
         end
         2'd1: begin
            trig_in.cos_v = -y_ff;
            trig_in.sin_v = x_ff;
         end
         2'd2: begin
            trig_in.cos_v = -x_ff;
            trig_in.sin_v = -y_ff;
         end
         default: begin
            trig_in.cos_v = y_ff;
            trig_in.sin_v = -x_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= fin_ff && !busy_ff && !start;
         if (start) begin
            x_ff    <= CORDIC_START;
            y_ff    <= '0;
            z_ff    <= {2'b00, angle[13:0]};
            quad_ff <= angle[15:14];
            step_ff <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (pos_in) begin
               x_ff <= x_ff - dx_in;
               y_ff <= y_ff + dy_in;
               z_ff <= z_ff - at_in;
            end else begin
               x_ff <= x_ff + dx_in;
               y_ff <= y_ff - dy_in;
               z_ff <= z_ff + at_in;
            end
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end else begin
               step_ff <= step_ff + 4'd1;
            end
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            trig_ff <= trig_in;
         end
      end
   end

   assign done = done_ff;
   assign trig = trig_ff;

endmodule

### rtl/mlvr_rotate.sv
// Rotates direction and plane vectors with one shared 16x32 multiplier, eight products in turn.
// Depends on mlvr_pkg.
module mlvr_rotate (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  mlvr_pkg::trig_type  trig,
   input  mlvr_pkg::vec_type   vec,
   output logic                done,
   output mlvr_pkg::vec_type   result
);
   import mlvr_pkg::*;

   logic               busy_ff, pv_ff, fin_ff, done_ff;
   logic [3:0]         issue_ff;
   logic [2:0]         pstep_ff;
   logic signed [47:0] prod_ff;
   logic signed [48:0] acc_ff;
   logic [1:0]         fidx_ff;
   logic signed [15:0] res_ff [4];

   logic [1:0]         o_in, po_in;
   logic               t_in, pt_in, psub_in;
   logic signed [15:0] va_in;
   logic signed [31:0] tv_in;
   logic signed [47:0] mul_in;
   logic signed [48:0] pext_in, sum_in, rnd_in;
   logic signed [18:0] r_in;
   logic signed [15:0] sat_in;

   always_comb begin
      o_in = issue_ff[2:1];
      t_in = issue_ff[0];
      case ({o_in[1], t_in})
         2'b00:   va_in = vec.dir_x;
         2'b01:   va_in = vec.dir_y;
         2'b10:   va_in = vec.plane_x;
         default: va_in = vec.plane_y;
      endcase
      tv_in  = (o_in[0] == t_in) ? trig.cos_v : trig.sin_v;
      mul_in = 48'(va_in) * 48'(tv_in);

      po_in   = pstep_ff[2:1];
      pt_in   = pstep_ff[0];
      psub_in = !po_in[0] && pt_in;
      pext_in = 49'(prod_ff);
      if (!pt_in) begin
         sum_in = pext_in;
      end else if (psub_in) begin
         sum_in = acc_ff - pext_in;
      end else begin
         sum_in = acc_ff + pext_in;
      end

      rnd_in = acc_ff + 49'sd536870912;
      r_in   = rnd_in[48:30];
      if (r_in > 19'sd32767) begin
         sat_in = 16'sd32767;
      end else if (r_in < -19'sd32768) begin
         sat_in = -16'sd32768;
      end else begin
         sat_in = r_in[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pv_ff   <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         pv_ff   <= busy_ff && !issue_ff[3] && !start;
         fin_ff  <= pv_ff && pt_in;
         done_ff <= fin_ff && (fidx_ff == 2'd3);
         if (start) begin
            busy_ff  <= 1'b1;
            issue_ff <= '0;
         end else if (busy_ff && !issue_ff[3]) begin
            prod_ff  <= mul_in;
            pstep_ff <= issue_ff[2:0];
            issue_ff <= issue_ff + 4'd1;
         end else if (fin_ff && (fidx_ff == 2'd3)) begin
            busy_ff <= 1'b0;
         end
         if (pv_ff) begin
            acc_ff <= sum_in;
            if (pt_in) begin
               fidx_ff <= po_in;
            end
         end
         if (fin_ff) begin
            res_ff[fidx_ff] <= sat_in;
         end
      end
   end

   assign done           = done_ff;
   assign result.dir_x   = res_ff[0];
   assign result.dir_y   = res_ff[1];
   assign result.plane_x = res_ff[2];
   assign result.plane_y = res_ff[3];

endmodule

### rtl/mouse_look_vector_rotator_core.sv
// Each pointer_x beat passes in turn through the edge test, the angle multiply, the
// fourteen-step CORDIC loop and its quarter fold, the eight products of the shared rotation
// multiplier, and the load of the output register before it returns to idle. An edge band
// beat skips the arithmetic. req_tready is high only while no event is in work; a finished
// result may wait in the output register while the next beat is taken. csr_ready is always
// high; write registers only while the block is idle. An event in the edge band returns the
// vectors unchanged with recenter set.
// Depends on mlvr_pkg, mlvr_cordic and mlvr_rotate.
module mouse_look_vector_rotator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [13:0] pointer_x
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // view_dir_x, view_dir_y, cam_plane_x, cam_plane_y
   output logic [0:0]  rsp_tuser,   // [0] recenter
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);
   import mlvr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_CORD,
      ST_ROT,
      ST_DONE
   } state_type;

   state_type          state_ff;
   logic               seen_ff, recenter_ff, rsp_valid_ff, rsp_recenter_ff;
   logic               cordic_start_ff, rot_start_ff;
   logic signed [13:0] prev_ff;
   logic signed [14:0] delta_ff;
   logic signed [31:0] angle_prod_ff;
   vec_type            vec_ff, rsp_vec_ff;

   logic [15:0]        sens_ff;
   logic [9:0]         margin_ff;
   vec_type            start_ff;

   logic signed [13:0] x_in;
   logic signed [14:0] x15_in, prev15_in, margin15_in;
   vec_type            vec_eff_in;
   logic               edge_in;
   logic signed [31:0] angle_sum_in;
   logic [15:0]        angle_in;
   logic               cordic_done, rot_done;
   trig_type           trig;
   vec_type            rot_result;

   always_comb begin
      x_in        = req_tdata[13:0];
      x15_in      = {x_in[13], x_in};
      prev15_in   = seen_ff ? {prev_ff[13], prev_ff} : {CENTER_X[13], CENTER_X};
      vec_eff_in  = seen_ff ? vec_ff : start_ff;
      margin15_in = {5'b00000, margin_ff};
      edge_in     = (x15_in < margin15_in) || (x15_in > (SCREEN_LIMIT - margin15_in));
      angle_sum_in = angle_prod_ff + 32'sd128;
      angle_in     = angle_sum_in[23:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff          <= RST_SENSITIVITY;
         margin_ff        <= RST_EDGE_MARGIN;
         start_ff.dir_x   <= RST_START_DIR_X;
         start_ff.dir_y   <= RST_START_DIR_Y;
         start_ff.plane_x <= RST_START_PLANE_X;
         start_ff.plane_y <= RST_START_PLANE_Y;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SENSITIVITY:   sens_ff          <= csr_data;
            CSR_EDGE_MARGIN:   margin_ff        <= csr_data[9:0];
            CSR_START_DIR_X:   start_ff.dir_x   <= csr_data;
            CSR_START_DIR_Y:   start_ff.dir_y   <= csr_data;
            CSR_START_PLANE_X: start_ff.plane_x <= csr_data;
            CSR_START_PLANE_Y: start_ff.plane_y <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         seen_ff         <= 1'b0;
         prev_ff         <= '0;
         vec_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         cordic_start_ff <= 1'b0;
         rot_start_ff    <= 1'b0;
      end else begin
         cordic_start_ff <= (state_ff == ST_ANGLE);
         rot_start_ff    <= (state_ff == ST_CORD) && cordic_done;
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  seen_ff     <= 1'b1;
                  vec_ff      <= vec_eff_in;
                  recenter_ff <= edge_in;
                  if (edge_in) begin
                     prev_ff  <= CENTER_X;
                     state_ff <= ST_DONE;
                  end else begin
                     prev_ff  <= x_in;
                     delta_ff <= x15_in - prev15_in;
                     state_ff <= ST_ANGLE;
                  end
               end
            end
            ST_ANGLE: begin
               angle_prod_ff <= 32'(delta_ff) * 32'($signed({1'b0, sens_ff}));
               state_ff      <= ST_CORD;
            end
            ST_CORD: begin
               if (cordic_done) begin
                  state_ff <= ST_ROT;
               end
            end
            ST_ROT: begin
               if (rot_done) begin
                  vec_ff   <= rot_result;
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_vec_ff      <= vec_ff;
                  rsp_recenter_ff <= recenter_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   mlvr_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start_ff),
      .angle (angle_in),
      .done  (cordic_done),
      .trig  (trig)
   );

   mlvr_rotate u_rotate (
      .clock  (clock),
      .reset  (reset),
      .start  (rot_start_ff),
      .trig   (trig),
      .vec    (vec_ff),
      .done   (rot_done),
      .result (rot_result)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_vec_ff;
   assign rsp_tuser  = rsp_recenter_ff;
   assign csr_ready  = 1'b1;

`ifndef ASSERT_OFF
   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while an event was in work");
   a_cordic_done_state: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> (state_ff == ST_CORD))
      else $error("sine/cosine finished outside its state");
   a_rot_done_state: assert property (@(posedge clock) disable iff (reset)
      rot_done |-> (state_ff == ST_ROT))
      else $error("rotation finished outside its state");
   a_recenter_no_rotate: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && edge_in) |=> (state_ff == ST_DONE))
      else $error("edge band event did not skip rotation");
`endif

endmodule
